// ----- rtl/core/pqsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pqsc_pkg
// Shared types and codes for the sorted priority queue with scheduling cursor.
// ----------------------------------------------------------------------------
package pqsc_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ID_W    = 32;
  localparam int PRIO_W  = 16;
  localparam int STAT_W  = 2;
  localparam int KIND_W  = 3;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_APPEND     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAKE_HEAD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAKE_SCHED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO_ID = 2'd3;

  // appended entries sit at priority -1
  localparam logic signed [PRIO_W-1:0] APPEND_PRIO = '1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [ID_W-1:0]          entry_id;
    logic signed [PRIO_W-1:0] priority_req;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [ID_W-1:0]          taken_id;
    logic signed [PRIO_W-1:0] taken_priority;
    logic [6:0]               count;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_TAIL,
    ST_TAKE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/pqsc_ram.sv -----
// ----------------------------------------------------------------------------
// pqsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/priority_queue_with_sched_cursor.sv -----
// ----------------------------------------------------------------------------
// priority_queue_with_sched_cursor
// Ordered queue of (id, signed priority) entries with a scheduling cursor.
// ----------------------------------------------------------------------------
// The queue lives in one 64 x 48 RAM with a registered read port; all
// reordering is done by a single walk over that RAM, one entry per cycle.
// Append, clear, unknown kinds and rejected items (zero id, full queue,
// empty take) go from idle straight to the result state. Insert into a
// non-empty queue walks from the head to the tail, placing the new entry in
// front of the first entry whose priority is not greater and sliding the
// rest back. A take reads the removed entry and slides everything behind
// it forward. cmd_ready is high only while the sequencer is idle; the
// result register holds a finished item until res_ready, and the next
// command is taken while it waits. Storage needs no clearing after reset:
// only positions below the count are ever read.
// ----------------------------------------------------------------------------
module priority_queue_with_sched_cursor (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pqsc_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output pqsc_pkg::res_t res
);
  import pqsc_pkg::*;

  // control state
  state_t           state, state_next;
  logic [CNT_W-1:0] occ, occ_next;          // entries held
  logic [IDX_W-1:0] cur_idx, cur_idx_next;  // scheduling cursor
  logic             cur_vld, cur_vld_next;
  logic             res_valid_next;

  // walk state
  logic [IDX_W-1:0] ra, ra_next;            // read address being issued
  logic             d_vld, d_vld_next;      // RAM data valid this cycle
  logic [IDX_W-1:0] d_idx, d_idx_next;      // address of the RAM data
  logic             placed, placed_next;    // insert: new entry written
  logic [IDX_W-1:0] ins_pos, ins_pos_next;  // insert: where it went
  logic [IDX_W-1:0] pos, pos_next;          // take: position removed

  // payload
  cmd_t              cmd_q, cmd_q_next;
  entry_t            held, held_next;       // entry displaced by the insert
  logic [STAT_W-1:0] rstat, rstat_next;
  entry_t            taken, taken_next;
  res_t              res_next;

  // RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  logic   cv_eff;
  logic   last;
  entry_t new_ent;

  pqsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra),
    .rdata (ram_rdata)
  );

  assign cmd_ready = (state == ST_IDLE);

  // a cursor past the tail counts as no cursor
  assign cv_eff  = cur_vld && ({1'b0, cur_idx} < occ);
  assign last    = d_vld && ({1'b0, d_idx} == (occ - CNT_W'(1)));
  assign new_ent = '{id: cmd_q.entry_id, prio: cmd_q.priority_req};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      cur_idx   <= '0;
      cur_vld   <= 1'b0;
      res_valid <= 1'b0;
      d_vld     <= 1'b0;
      placed    <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      cur_idx   <= cur_idx_next;
      cur_vld   <= cur_vld_next;
      res_valid <= res_valid_next;
      d_vld     <= d_vld_next;
      placed    <= placed_next;
    end
  end

  always_ff @(posedge clk) begin
    ra      <= ra_next;
    d_idx   <= d_idx_next;
    ins_pos <= ins_pos_next;
    pos     <= pos_next;
    cmd_q   <= cmd_q_next;
    held    <= held_next;
    rstat   <= rstat_next;
    taken   <= taken_next;
    res     <= res_next;
  end

  always_comb begin
    state_next     = state;
    occ_next       = occ;
    cur_idx_next   = cur_idx;
    cur_vld_next   = cur_vld;
    res_valid_next = res_valid;
    ra_next        = ra;
    d_vld_next     = 1'b0;
    d_idx_next     = d_idx;
    placed_next    = placed;
    ins_pos_next   = ins_pos;
    pos_next       = pos;
    cmd_q_next     = cmd_q;
    held_next      = held;
    rstat_next     = rstat;
    taken_next     = taken;
    res_next       = res;
    ram_we         = 1'b0;
    ram_waddr      = occ[IDX_W-1:0];
    ram_wdata      = new_ent;

    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_q_next   = cmd;
          cur_vld_next = cv_eff;
          rstat_next   = STAT_DONE;
          taken_next   = '0;
          placed_next  = 1'b0;
          state_next   = ST_DONE;
          case (cmd.kind)
            KIND_APPEND, KIND_INSERT: begin
              if (cmd.entry_id == '0) begin
                rstat_next = STAT_ZERO_ID;
              end else if (occ == CNT_W'(DEPTH)) begin
                rstat_next = STAT_FULL;
              end else if (cmd.kind == KIND_APPEND) begin
                ram_we    = 1'b1;
                ram_waddr = occ[IDX_W-1:0];
                ram_wdata = '{id: cmd.entry_id, prio: APPEND_PRIO};
                occ_next  = occ + CNT_W'(1);
                if (!cv_eff) begin
                  cur_idx_next = occ[IDX_W-1:0];
                  cur_vld_next = 1'b1;
                end
              end else if (occ == '0) begin
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = '{id: cmd.entry_id, prio: cmd.priority_req};
                occ_next     = CNT_W'(1);
                cur_idx_next = '0;
                cur_vld_next = 1'b1;
              end else begin
                ra_next    = '0;
                state_next = ST_INS;
              end
            end
            KIND_TAKE_HEAD, KIND_TAKE_SCHED: begin
              if (occ == '0) begin
                rstat_next = STAT_EMPTY;
              end else if (cmd.kind == KIND_TAKE_HEAD) begin
                pos_next   = '0;
                ra_next    = '0;
                state_next = ST_TAKE;
              end else begin
                // no cursor restarts at the head
                pos_next     = cv_eff ? cur_idx : '0;
                ra_next      = cv_eff ? cur_idx : '0;
                cur_idx_next = cv_eff ? cur_idx : '0;
                cur_vld_next = 1'b1;
                state_next   = ST_TAKE;
              end
            end
            KIND_CLEAR: begin
              occ_next     = '0;
              cur_idx_next = '0;
              cur_vld_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // head-to-tail walk: find the slot, then ripple entries back by one
      ST_INS: begin
        ra_next    = ra + IDX_W'(1);
        d_vld_next = 1'b1;
        d_idx_next = ra;
        if (d_vld) begin
          ram_waddr = d_idx;
          if (placed) begin
            ram_we    = 1'b1;
            ram_wdata = held;
            held_next = ram_rdata;
          end else if (ram_rdata.prio <= cmd_q.priority_req) begin
            ram_we       = 1'b1;
            ram_wdata    = new_ent;
            held_next    = ram_rdata;
            placed_next  = 1'b1;
            ins_pos_next = d_idx;
          end
        end
        if (last) begin
          d_vld_next = 1'b0;
          state_next = ST_INS_TAIL;
        end
      end

      ST_INS_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = occ[IDX_W-1:0];
        ram_wdata = placed ? held : new_ent;
        occ_next  = occ + CNT_W'(1);
        // cursor follows its entry when the insert lands at or before it
        if (placed && cur_vld && (cur_idx >= ins_pos)) begin
          cur_idx_next = cur_idx + IDX_W'(1);
        end
        state_next = ST_DONE;
      end

      // read the removed entry, then slide the tail forward by one
      ST_TAKE: begin
        ra_next    = ra + IDX_W'(1);
        d_vld_next = 1'b1;
        d_idx_next = ra;
        if (d_vld) begin
          if (d_idx == pos) begin
            taken_next = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = d_idx - IDX_W'(1);
            ram_wdata = ram_rdata;
          end
        end
        if (last) begin
          d_vld_next = 1'b0;
          occ_next   = occ - CNT_W'(1);
          if (cmd_q.kind == KIND_TAKE_HEAD) begin
            if (cur_vld) begin
              if (cur_idx != '0) begin
                cur_idx_next = cur_idx - IDX_W'(1);
              end else if (occ == CNT_W'(1)) begin
                cur_vld_next = 1'b0;
              end
            end
          end else if ({1'b0, pos} >= (occ - CNT_W'(1))) begin
            // cursor ran off the tail
            cur_vld_next = 1'b0;
            cur_idx_next = '0;
          end
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!res_valid || res_ready) begin
          res_next.status         = rstat;
          res_next.taken_id       = taken.id;
          res_next.taken_priority = taken.prio;
          res_next.count          = occ;
          res_valid_next          = 1'b1;
          state_next              = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- bench/priority_queue_with_sched_cursor_test.sv -----
// ----------------------------------------------------------------------------
// priority_queue_with_sched_cursor_test
// Self-checking bench for the sorted priority queue with scheduling cursor.
// A queue-driven command driver and a result monitor run at random pace on
// both valid/ready channels. A behavioral copy of the queue, its cursor and its
// count predicts every result at command accept. The monitor compares each
// result field by field, in order. Stimulus is a short directed opener and
// then random phases. Those phases fill the queue to full, drain it, and mix
// appends, priority inserts, head takes and cursor takes.
// ----------------------------------------------------------------------------
module priority_queue_with_sched_cursor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pqsc_pkg::*;

  // kinds above clear are spare: the block answers them with done + count
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_CYCLES  = 80;

  // stimulus phases for the random part
  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED,
    PH_CURSOR
  } phase_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  priority_queue_with_sched_cursor u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted queue: entries head first, count, and the scheduling cursor.
  // --------------------------------------------------------------------------
  entry_t model_slots [DEPTH];
  int     model_held      = 0;
  int     model_cursor    = 0;
  bit     model_cursor_ok = 1'b0;

  cmd_t   cmd_backlog [$];   // items waiting to be driven
  res_t   queue_replies [$]; // predicted results, oldest first

  int     plan_count   = 0;  // count as tracked while building stimulus
  int     failures     = 0;
  int     items_sent   = 0;
  int     results_seen = 0;
  int     hits_full    = 0;
  int     hits_zero_id = 0;
  int     hits_empty   = 0;
  int     peak_held    = 0;

  // Pull the entry at pos out and close the gap behind it.
  task automatic remove_slot(input int pos, output entry_t gone);
    int i;
    gone = model_slots[pos];
    for (i = pos; i + 1 < model_held; i++)
      model_slots[i] = model_slots[i + 1];
    model_held--;
  endtask

  // One queue operation against the predicted state; returns its result.
  task automatic apply_queue_op(input cmd_t c, output res_t r);
    int     pos;
    int     i;
    entry_t gone;
    bit     was_empty;
    r    = '0;
    gone = '0;
    pos  = 0;
    // a cursor left past the tail by earlier takes is stale
    if (model_cursor_ok && model_cursor >= model_held)
      model_cursor_ok = 1'b0;

    if (c.kind == KIND_APPEND || c.kind == KIND_INSERT) begin
      // zero id is checked ahead of the full check
      if (c.entry_id == '0) begin
        r.status = STAT_ZERO_ID;
        hits_zero_id++;
      end else if (model_held >= DEPTH) begin
        r.status = STAT_FULL;
        hits_full++;
      end else if (c.kind == KIND_APPEND) begin
        model_slots[model_held].id   = c.entry_id;
        model_slots[model_held].prio = APPEND_PRIO;
        model_held++;
        // append claims the cursor only when there is none
        if (!model_cursor_ok) begin
          model_cursor    = model_held - 1;
          model_cursor_ok = 1'b1;
        end
      end else begin
        was_empty = (model_held == 0);
        // stop at first entry not strictly greater: ties go newest first
        while (pos < model_held && $signed(model_slots[pos].prio) > $signed(c.priority_req))
          pos++;
        for (i = model_held; i > pos; i--)
          model_slots[i] = model_slots[i - 1];
        model_slots[pos].id   = c.entry_id;
        model_slots[pos].prio = c.priority_req;
        model_held++;
        if (was_empty) begin
          model_cursor    = 0;
          model_cursor_ok = 1'b1;
        end else if (model_cursor_ok && model_cursor >= pos) begin
          model_cursor++; // keep pointing at the same entry
        end
      end
    end else if (c.kind == KIND_TAKE_HEAD) begin
      if (model_held == 0) begin
        r.status = STAT_EMPTY;
        hits_empty++;
      end else begin
        remove_slot(0, gone);
        if (model_cursor_ok) begin
          if (model_cursor > 0)
            model_cursor--;
          else if (model_held == 0)
            model_cursor_ok = 1'b0;
        end
      end
    end else if (c.kind == KIND_TAKE_SCHED) begin
      if (model_held == 0) begin
        r.status = STAT_EMPTY;
        hits_empty++;
      end else begin
        // no cursor: restart at the head
        if (!model_cursor_ok) begin
          model_cursor    = 0;
          model_cursor_ok = 1'b1;
        end
        remove_slot(model_cursor, gone);
        // cursor now sits on the follower; ran off the end -> dropped
        if (model_cursor >= model_held) begin
          model_cursor_ok = 1'b0;
          model_cursor    = 0;
        end
      end
    end else if (c.kind == KIND_CLEAR) begin
      model_held      = 0;
      model_cursor    = 0;
      model_cursor_ok = 1'b0;
    end

    if (model_held > peak_held)
      peak_held = model_held;
    r.taken_id       = gone.id;
    r.taken_priority = gone.prio;
    r.count          = 7'(model_held);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Queue one item and track the count it should leave behind.
  task automatic add_cmd(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                         input logic signed [PRIO_W-1:0] prio);
    cmd_t c;
    c.kind         = kind;
    c.entry_id     = id;
    c.priority_req = prio;
    cmd_backlog.push_back(c);
    if ((kind == KIND_APPEND || kind == KIND_INSERT) && id != '0 && plan_count < DEPTH)
      plan_count++;
    else if ((kind == KIND_TAKE_HEAD || kind == KIND_TAKE_SCHED) && plan_count > 0)
      plan_count--;
    else if (kind == KIND_CLEAR)
      plan_count = 0;
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      return '0;
    if (roll < 7)
      return '1;
    return $urandom;
  endfunction

  // Narrow range for two draws in five so equal priorities collide often.
  function automatic logic signed [PRIO_W-1:0] rand_prio();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)
      return PRIO_W'($signed($urandom_range(0, 6)) - 3);
    if (roll < 45)
      return {1'b0, {(PRIO_W-1){1'b1}}};
    if (roll < 50)
      return {1'b1, {(PRIO_W-1){1'b0}}};
    return PRIO_W'($urandom);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll == 0)
      return KIND_CLEAR;
    if (roll == 1)
      return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL:
        return roll < 45 ? KIND_INSERT : roll < 80 ? KIND_APPEND :
               roll < 90 ? KIND_TAKE_HEAD : KIND_TAKE_SCHED;
      PH_DRAIN:
        return roll < 45 ? KIND_TAKE_SCHED : roll < 80 ? KIND_TAKE_HEAD :
               roll < 90 ? KIND_INSERT : KIND_APPEND;
      PH_CURSOR:
        return roll < 30 ? KIND_APPEND : roll < 50 ? KIND_INSERT :
               roll < 90 ? KIND_TAKE_SCHED : KIND_TAKE_HEAD;
      default:
        return KIND_W'($urandom_range(KIND_APPEND, KIND_TAKE_SCHED));
    endcase
  endfunction

  // Per-item wait drawn at random, with occasional stretches of back-to-back items.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      quiet = $urandom_range(8, 40);
    return $urandom_range(0, 11);
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: feeds the backlog, predicts on accept.
  // --------------------------------------------------------------------------
  int send_gap   = 0;
  int send_quiet = 0;

  always @(posedge clk) begin
    res_t predicted;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        apply_queue_op(cmd, predicted);
        queue_replies.push_back(predicted);
        items_sent++;
      end
      // hold valid and payload until the item is taken
      if (cmd_valid && !cmd_ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cmd       <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        send_gap  = draw_gap(send_quiet);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random back-pressure, in-order field compare.
  // --------------------------------------------------------------------------
  int take_stall = 0;
  int take_quiet = 0;

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (queue_replies.size() == 0) begin
          $error("result with no item outstanding: status %0d id %0h count %0d",
                 res.status, res.taken_id, res.count);
          failures++;
        end else begin
          want = queue_replies.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            failures++;
          end
          if (res.taken_id !== want.taken_id) begin
            $error("taken_id: expected %0h, got %0h", want.taken_id, res.taken_id);
            failures++;
          end
          if (res.taken_priority !== want.taken_priority) begin
            $error("taken_priority: expected %0d, got %0d",
                   $signed(want.taken_priority), $signed(res.taken_priority));
            failures++;
          end
          if (res.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, res.count);
            failures++;
          end
        end
        take_stall = draw_gap(take_quiet);
      end else if (take_stall > 0) begin
        take_stall--;
      end
      res_ready <= (take_stall == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus build, reset, and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int     random_count;
    int     phase_len;
    int     extra;
    phase_t ph;
    logic [KIND_W-1:0] k;

    // Directed opener: empty takes, zero ids, id and priority extremes,
    // ties with appended entries, cursor moves, spare kinds, clear.
    add_cmd(KIND_TAKE_HEAD,  '0, '0);
    add_cmd(KIND_TAKE_SCHED, '1, '1);
    add_cmd(KIND_APPEND,     '0, '0);
    add_cmd(KIND_INSERT,     '0, '1);
    add_cmd(KIND_APPEND,     '1, '0);                      // sets cursor on empty
    add_cmd(KIND_INSERT,     32'h0000_0001, 16'sh7FFF);     // top priority
    add_cmd(KIND_INSERT,     32'h8000_0000, -16'sh8000);    // bottom priority
    add_cmd(KIND_INSERT,     32'h5555_5555, -16'sd1);       // ties an appended entry
    add_cmd(KIND_INSERT,     32'hAAAA_AAAA, 16'sd0);
    add_cmd(KIND_TAKE_SCHED, 32'h1234_5678, 16'sh5A5A);
    add_cmd(KIND_TAKE_SCHED, '0, '0);
    add_cmd(KIND_TAKE_HEAD,  '0, '0);
    for (k = KIND_SPARE_FIRST; k != KIND_SPARE_LAST; k++)
      add_cmd(k, 32'hDEAD_BEEF, -16'sd2);
    add_cmd(KIND_SPARE_LAST, 32'hDEAD_BEEF, -16'sd2);
    add_cmd(KIND_TAKE_SCHED, '0, '0);
    add_cmd(KIND_TAKE_SCHED, '0, '0);                       // takes the last entry, cursor runs off
    add_cmd(KIND_CLEAR,      '1, '1);
    add_cmd(KIND_TAKE_SCHED, '0, '0);
    add_cmd(KIND_INSERT,     32'h0F0F_0F0F, 16'sd5);        // insert into empty
    add_cmd(KIND_APPEND,     32'h0000_0002, '0);            // cursor already set
    add_cmd(KIND_TAKE_HEAD,  '0, '0);                       // cursor was at head
    add_cmd(KIND_TAKE_HEAD,  '0, '0);
    add_cmd(KIND_TAKE_HEAD,  '0, '0);

    // Random part opens with a fill to full, then rejects on a full queue.
    random_count = 0;
    while (plan_count < DEPTH) begin
      add_cmd($urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND, rand_id(), rand_prio());
      random_count++;
    end
    add_cmd(KIND_APPEND, rand_id() | 32'h1, rand_prio());
    add_cmd(KIND_INSERT, rand_id() | 32'h1, rand_prio());
    add_cmd(KIND_INSERT, '0, rand_prio());
    random_count += 3;

    while (random_count < RANDOM_ITEMS) begin
      ph        = phase_t'($urandom_range(PH_FILL, PH_CURSOR));
      phase_len = $urandom_range(10, 60);
      for (extra = 0; extra < phase_len && random_count < RANDOM_ITEMS; extra++) begin
        k = pick_kind(ph);
        add_cmd(k, rand_id(), rand_prio());
        if (k <= KIND_CLEAR)
          random_count++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // settle on the falling edge so driver and monitor updates are visible
    while (cmd_backlog.size() != 0 || cmd_valid || queue_replies.size() != 0)
      @(negedge clk);
    // quiet tail: any late result here is an unexpected one
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results; queue peaked at %0d entries.",
             items_sent, results_seen, peak_held);
    $display("Rejects seen: %0d full, %0d zero id, %0d empty take.",
             hits_full, hits_zero_id, hits_empty);
    if (failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("run timed out");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
